// ===== src/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication checked every clock outside reset
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== src/rmsn_pkg.sv =====
`timescale 1ns / 1ps
package rmsn_pkg;

   localparam int unsigned MaxLengthDefault = 4096;
   localparam int unsigned SampleWidth = 16;
   localparam int unsigned EpsWidth = 24;
   localparam int unsigned SumWidth = 43;
   localparam int unsigned ScaleWidth = 32;
   localparam int unsigned RadWidth = 88;
   localparam int unsigned RootWidth = 44;
   localparam int unsigned QuotWidth = 49;
   localparam logic [31:0] ScaleMax = 32'hFFFF_FFFF;
   localparam logic [0:0] ModeAccum = 1'b0;
   localparam logic [0:0] ModeApply = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic accum;
      logic div_start;
      logic div_step;
      logic sqrt_start;
      logic sqrt_step;
      logic recip_start;
      logic recip_step;
      logic scale_load;
      logic apply0;
      logic apply1;
      logic apply2;
   } ctrl_type;

endpackage

// ===== src/rmsn_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rmsn_datapath #(
   parameter int unsigned MAX_LENGTH = rmsn_pkg::MaxLengthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rmsn_pkg::ctrl_type    ctrl,
   input  logic [23:0]           epsilon,
   input  logic                  mode,
   input  logic signed [15:0]    sample,
   input  logic signed [15:0]    gain,
   input  logic                  last,
   output logic                  last_accum,
   output logic signed [15:0]    rsp_normalized,
   output logic                  rsp_end_of_vector,
   output logic                  rsp_clipped
);

   localparam int unsigned CountWidth = $clog2(MAX_LENGTH + 1);

   logic [42:0] sum_ff, sum_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic [31:0] scale_ff, scale_in;
   // captured request
   logic [15:0] smag_ff, gmag_ff;
   logic neg_ff, last_ff;
   logic [15:0] smag, gmag;
   logic sneg, gneg;
   // restoring divider: sum / count
   logic [42:0] dq_ff, dq_in;
   logic [CountWidth:0] drem_ff, drem_in;
   logic [CountWidth:0] dtrial;
   // sqrt
   logic [87:0] rad_ff, rad_in;
   logic [45:0] srem_ff, srem_in;
   logic [43:0] root_ff, root_in;
   logic [45:0] strial;
   // reciprocal
   logic [48:0] num_ff, num_in;
   logic [48:0] q_ff, q_in;
   logic [44:0] rrem_ff, rrem_in;
   logic [44:0] rtrial;
   // apply
   logic [31:0] p1_ff, p1_in;
   logic [63:0] p2_ff, p2_in;
   logic [29:0] rnd;
   logic [15:0] val;
   logic clip;

   assign smag = sample[15] ? 16'(17'h10000 - {1'b0, sample}) : sample;
   assign gmag = gain[15] ? 16'(17'h10000 - {1'b0, gain}) : gain;
   assign sneg = sample[15];
   assign gneg = gain[15];
   assign last_accum = (mode == rmsn_pkg::ModeAccum) && last;

   // trial subtractions for the divider, square root and reciprocal steps
   assign dtrial = {drem_ff[CountWidth-1:0], dq_ff[42]} - {1'b0, cnt_ff};
   assign strial = {srem_ff[43:0], rad_ff[87:86]} - {root_ff, 2'b01};
   assign rtrial = {rrem_ff[43:0], num_ff[48]} - {1'b0, root_ff};

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      dq_in = dq_ff;
      drem_in = drem_ff;
      rad_in = rad_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      num_in = num_ff;
      q_in = q_ff;
      rrem_in = rrem_ff;
      scale_in = scale_ff;
      if (ctrl.accum && cnt_ff < CountWidth'(MAX_LENGTH)) begin
         sum_in = sum_ff + 43'(32'(smag) * 32'(smag));
         cnt_in = cnt_ff + 1'b1;
      end
      if (ctrl.div_start) begin
         dq_in = sum_in;
         drem_in = '0;
         cnt_in = cnt_in;
      end
      if (ctrl.div_step) begin
         if (!dtrial[CountWidth]) begin
            drem_in = dtrial;
            dq_in = {dq_ff[41:0], 1'b1};
         end else begin
            drem_in = {drem_ff[CountWidth-1:0], dq_ff[42]};
            dq_in = {dq_ff[41:0], 1'b0};
         end
      end
      if (ctrl.sqrt_start) begin
         // count is zero only if nothing was counted: mean is then zero
         rad_in = {(cnt_ff == '0 ? 44'd0 : 44'(dq_ff)) + 44'(epsilon), 32'd0, 12'd0};
         rad_in = {12'd0, rad_in[87:12]};
         srem_in = '0;
         root_in = '0;
         sum_in = '0;
         cnt_in = '0;
      end
      if (ctrl.sqrt_step) begin
         rad_in = {rad_ff[85:0], 2'b00};
         if (!strial[45]) begin
            srem_in = strial;
            root_in = {root_ff[42:0], 1'b1};
         end else begin
            srem_in = {srem_ff[43:0], rad_ff[87:86]};
            root_in = {root_ff[42:0], 1'b0};
         end
      end
      if (ctrl.recip_start) begin
         num_in = 49'(64'h1_0000_0000_0000 + 64'(root_ff >> 1));
         q_in = '0;
         rrem_in = '0;
      end
      if (ctrl.recip_step) begin
         num_in = {num_ff[47:0], 1'b0};
         if (!rtrial[44]) begin
            rrem_in = rtrial;
            q_in = {q_ff[47:0], 1'b1};
         end else begin
            rrem_in = {rrem_ff[43:0], num_ff[48]};
            q_in = {q_ff[47:0], 1'b0};
         end
      end
      if (ctrl.scale_load) begin
         if (root_ff == '0 || q_ff[48:32] != '0) scale_in = rmsn_pkg::ScaleMax;
         else scale_in = q_ff[31:0];
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
         scale_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         scale_ff <= scale_in;
      end
   end

   // iteration registers
   always_ff @(posedge clock) begin
      dq_ff <= dq_in;
      drem_ff <= drem_in;
      rad_ff <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      num_ff <= num_in;
      q_ff <= q_in;
      rrem_ff <= rrem_in;
   end

   // apply pipeline: two multiplies then round and saturate
   assign p1_in = smag_ff * gmag_ff;
   assign p2_in = p1_ff * scale_ff;
   assign rnd = 30'((p2_ff + 64'h2_0000_0000) >> 34);
   always_comb begin
      clip = 1'b0;
      if (neg_ff && rnd != '0) begin
         if (rnd > 30'd32768) begin
            clip = 1'b1;
            val = 16'h8000;
         end else begin
            val = 16'(17'h10000 - 17'(rnd));
         end
      end else if (rnd > 30'd32767) begin
         clip = 1'b1;
         val = 16'h7FFF;
      end else begin
         val = 16'(rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.apply0) begin
         smag_ff <= smag;
         gmag_ff <= gmag;
         neg_ff <= sneg ^ gneg;
         last_ff <= last;
      end
      if (ctrl.apply1) p1_ff <= p1_in;
      if (ctrl.apply2) p2_ff <= p2_in;
   end

   assign rsp_normalized = val;
   assign rsp_end_of_vector = last_ff;
   assign rsp_clipped = clip;

   `ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CountWidth'(MAX_LENGTH),
      "element count above maximum")
   `ASSERT_NEXT(a_sqrt_clears, clock, reset, ctrl.sqrt_start, sum_ff == '0 && cnt_ff == '0,
      "sum not cleared at scale computation")

endmodule

// ===== src/rmsn_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rmsn_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               mode,
   input  logic               last_accum,
   output logic               busy,
   output logic               rsp_valid,
   output rmsn_pkg::ctrl_type ctrl
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV = 3'd1;
   localparam logic [2:0] S_SQRT = 3'd2;
   localparam logic [2:0] S_RECIP = 3'd3;
   localparam logic [2:0] S_LOAD = 3'd4;
   localparam logic [2:0] S_MUL = 3'd5;
   localparam logic [2:0] S_PROD = 3'd6;
   localparam logic [2:0] S_OUT = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [5:0] step_ff, step_in;
   logic accept;

   assign accept = start && !busy;
   assign busy = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_OUT;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      ctrl = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (mode == rmsn_pkg::ModeApply) begin
                  ctrl.apply0 = 1'b1;
                  state_in = S_MUL;
               end else begin
                  ctrl.accum = 1'b1;
                  if (last_accum) begin
                     ctrl.div_start = 1'b1;
                     step_in = 6'd42;
                     state_in = S_DIV;
                  end
               end
            end
         end
         S_DIV: begin
            ctrl.div_step = 1'b1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            ctrl.sqrt_start = 1'b1;
            step_in = 6'd43;
            state_in = S_RECIP;
         end
         S_RECIP: begin
            ctrl.sqrt_step = 1'b1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = S_LOAD;
               step_in = 6'd49;
            end
         end
         S_LOAD: begin
            if (step_ff == 6'd49) begin
               ctrl.recip_start = 1'b1;
               step_in = 6'd48;
            end else if (step_ff == 6'd63) begin
               // last quotient bit is in, latch the scale
               ctrl.scale_load = 1'b1;
               state_in = S_IDLE;
            end else begin
               ctrl.recip_step = 1'b1;
               step_in = step_ff - 1'b1;
            end
         end
         S_MUL: begin
            ctrl.apply1 = 1'b1;
            state_in = S_PROD;
         end
         S_PROD: begin
            ctrl.apply2 = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   `ASSERT_IMPL(a_busy_no_start, clock, reset, accept, state_ff == S_IDLE,
      "request accepted while busy")
   `ASSERT_NEXT(a_apply_flow, clock, reset, accept && mode == rmsn_pkg::ModeApply,
      state_ff == S_MUL, "apply request did not enter multiply")

endmodule

// ===== src/rms_norm_vector.sv =====
`timescale 1ns / 1ps
// RMS normalisation, two passes. An accumulate request (mode 0) leaves busy
// low unless last is set; one with last set holds busy while a
// bit-serial divider (43 steps), square root (44 steps) and reciprocal
// divider (49 steps) form the scale, with a step each to start the root,
// start the reciprocal and load the scale. An apply request (mode 1) holds
// busy through two registered multiplies and the output state, and gives one
// response on rsp_valid for exactly one cycle in that output state; the receiver
// cannot stall it.
module rms_norm_vector #(
   parameter int unsigned MAX_LENGTH = rmsn_pkg::MaxLengthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_mode,
   input  logic signed [15:0] req_sample,
   input  logic signed [15:0] req_gain,
   input  logic               req_last,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_normalized,
   output logic               rsp_end_of_vector,
   output logic               rsp_clipped,
   input  logic               csr_write,
   input  logic [23:0]        csr_epsilon
);

   logic [23:0] eps_ff;
   rmsn_pkg::ctrl_type ctrl;
   logic last_accum;

   // epsilon register
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= 24'd17;
      end else if (csr_write) begin
         eps_ff <= csr_epsilon;
      end
   end

   rmsn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .mode       (req_mode),
      .last_accum (last_accum),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .ctrl       (ctrl)
   );

   rmsn_datapath #(.MAX_LENGTH(MAX_LENGTH)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .epsilon           (eps_ff),
      .mode              (req_mode),
      .sample            (req_sample),
      .gain              (req_gain),
      .last              (req_last),
      .last_accum        (last_accum),
      .rsp_normalized    (rsp_normalized),
      .rsp_end_of_vector (rsp_end_of_vector),
      .rsp_clipped       (rsp_clipped)
   );

endmodule
